// ===== sv/ghtp_pkg.sv =====
// Shared types and constants for the GUID hex text parser.
package ghtp_pkg;

    // Group sequencing
    localparam logic [3:0] GroupCount     = 4'd11;
    localparam logic [3:0] TailFirstGroup = 4'd3;
    localparam logic [3:0] FirstLimit     = 4'd8;
    localparam logic [3:0] MidLimit       = 4'd4;
    localparam logic [3:0] TailLimit      = 4'd2;
    localparam int         TailByteCount  = 8;

    // Character that ends the string
    localparam logic [7:0] EndChar = 8'h00;

    // Decoded character
    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
    } t_hex;

    // One parsed GUID
    typedef struct packed {
        logic [31:0] part_one;
        logic [15:0] part_two;
        logic [15:0] part_three;
        logic [63:0] tail_bytes;
        logic        trailing_error;
    } t_result;

endpackage

// ===== sv/ghtp_if.sv =====
// Valid/ready channel interfaces for the character input and the parsed result.
interface ghtp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ghtp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] part_one;
    logic [15:0] part_two;
    logic [15:0] part_three;
    logic [63:0] tail_bytes;
    logic        trailing_error;

    modport source (output valid, output part_one, output part_two, output part_three,
                    output tail_bytes, output trailing_error, input ready);
    modport sink   (input valid, input part_one, input part_two, input part_three,
                    input tail_bytes, input trailing_error, output ready);
endinterface

// ===== sv/guid_hex_text_parser.sv =====
// GUID hex text parser top level: input register, parser core and result register.
// Takes one character per clock cycle on i_char and emits one parsed GUID on o_result
// for every zero byte. A character is registered on acceptance and processed from the
// input register, a zero byte only once the result register is free; that register then
// loads the core's snapshot and raises o_result.valid. Throughput is one
// character per cycle; i_char.ready drops only while a zero byte sits in the input
// register and the output register still holds a result that the sink has not taken.
module guid_hex_text_parser
    import ghtp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ghtp_char_if.sink     i_char,
    ghtp_result_if.source o_result
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_snapshot;
    logic       w_out_free;
    logic       w_advance;
    logic       w_emit;

    // Output register can take a new result
    assign w_out_free = !r_out_valid || o_result.ready;
    // Held character is consumed this cycle
    assign w_advance  = r_in_valid && ((r_in_char != EndChar) || w_out_free);
    assign w_emit     = w_advance && (r_in_char == EndChar);

    assign i_char.ready = !r_in_valid || w_advance;

    ghtp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_char   (r_in_char),
        .o_result (w_snapshot)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_snapshot;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.part_one       = r_out.part_one;
    assign o_result.part_two       = r_out.part_two;
    assign o_result.part_three     = r_out.part_three;
    assign o_result.tail_bytes     = r_out.tail_bytes;
    assign o_result.trailing_error = r_out.trailing_error;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !w_emit)
        else $error("result overwritten before transaction");

    // A stalled end character keeps the input register full
    a_end_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_char == EndChar) && !w_out_free) |=>
        (r_in_valid && (r_in_char == EndChar)))
        else $error("stalled end character lost");

    // Every emitted result shows up as valid
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid)
        else $error("emitted result not presented");

endmodule

// ===== sv/ghtp_hex_decode.sv =====
// Hex digit classifier: ASCII character to nibble value plus a hex flag.
module ghtp_hex_decode
    import ghtp_pkg::*;
(
    input  logic [7:0] i_char,
    output t_hex       o_hex
);

    // '0'-'9', 'A'-'F' and 'a'-'f'; everything else is a separator
    always_comb begin
        o_hex = '{is_hex: 1'b0, nibble: 4'd0};
        case (i_char) inside
            [8'h30:8'h39]: begin
                o_hex = '{is_hex: 1'b1, nibble: i_char[3:0]};
            end
            [8'h41:8'h46], [8'h61:8'h66]: begin
                o_hex = '{is_hex: 1'b1, nibble: 4'(i_char[3:0] + 4'd9)};
            end
            default: begin
                o_hex = '{is_hex: 1'b0, nibble: 4'd0};
            end
        endcase
    end

endmodule

// ===== sv/ghtp_core.sv =====
// Parser state: group sequencing, digit counting and the GUID field registers.
module ghtp_core
    import ghtp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    output t_result    o_result
);

    t_hex        w_hex;
    logic        w_end;
    logic [3:0]  w_limit;
    logic [3:0]  w_digits_inc;

    logic [3:0]  r_group, n_group;
    logic [3:0]  r_digits, n_digits;
    logic        r_inside, n_inside;
    logic        r_error, n_error;
    logic [31:0] r_first, n_first;
    logic [15:0] r_second, n_second;
    logic [15:0] r_third, n_third;
    logic [7:0]  r_tail [TailByteCount];
    logic [7:0]  n_tail [TailByteCount];

    ghtp_hex_decode u_decode (
        .i_char (i_char),
        .o_hex  (w_hex)
    );

    assign w_end        = (i_char == EndChar);
    assign w_digits_inc = 4'(r_digits + 4'd1);

    // Digit count of the current group
    always_comb begin
        if (r_group == 4'd0) begin
            w_limit = FirstLimit;
        end else if (r_group < TailFirstGroup) begin
            w_limit = MidLimit;
        end else begin
            w_limit = TailLimit;
        end
    end

    // Sequencing and the three leading groups
    always_comb begin
        n_group  = r_group;
        n_digits = r_digits;
        n_inside = r_inside;
        n_error  = r_error;
        n_first  = r_first;
        n_second = r_second;
        n_third  = r_third;
        if (i_fire) begin
            if (w_end) begin
                n_group  = 4'd0;
                n_digits = 4'd0;
                n_inside = 1'b0;
                n_error  = 1'b0;
                n_first  = '0;
                n_second = '0;
                n_third  = '0;
            end else if (r_group >= GroupCount) begin
                if (w_hex.is_hex) begin
                    n_error = 1'b1;
                end
            end else if (!w_hex.is_hex) begin
                // separator closes an open group
                if (r_inside) begin
                    n_group  = 4'(r_group + 4'd1);
                    n_digits = 4'd0;
                    n_inside = 1'b0;
                end
            end else begin
                if (r_group == 4'd0) begin
                    n_first = {r_first[27:0], w_hex.nibble};
                end
                if (r_group == 4'd1) begin
                    n_second = {r_second[11:0], w_hex.nibble};
                end
                if (r_group == 4'd2) begin
                    n_third = {r_third[11:0], w_hex.nibble};
                end
                if (w_digits_inc >= w_limit) begin
                    n_group  = 4'(r_group + 4'd1);
                    n_digits = 4'd0;
                    n_inside = 1'b0;
                end else begin
                    n_digits = w_digits_inc;
                    n_inside = 1'b1;
                end
            end
        end
    end

    // One byte lane per tail group
    for (genvar gi = 0; gi < TailByteCount; gi++) begin : g_tail
        always_comb begin
            n_tail[gi] = r_tail[gi];
            if (i_fire) begin
                if (w_end) begin
                    n_tail[gi] = '0;
                end else if (w_hex.is_hex && (r_group == 4'(TailFirstGroup + gi))) begin
                    n_tail[gi] = {r_tail[gi][3:0], w_hex.nibble};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tail[gi] <= '0;
            end else begin
                r_tail[gi] <= n_tail[gi];
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group  <= 4'd0;
            r_digits <= 4'd0;
            r_inside <= 1'b0;
            r_error  <= 1'b0;
            r_first  <= '0;
            r_second <= '0;
            r_third  <= '0;
        end else begin
            r_group  <= n_group;
            r_digits <= n_digits;
            r_inside <= n_inside;
            r_error  <= n_error;
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
        end
    end

    // Snapshot of the fields; taken by the top level on the end character
    assign o_result = '{
        part_one:       r_first,
        part_two:       r_second,
        part_three:     r_third,
        tail_bytes:     {r_tail[0], r_tail[1], r_tail[2], r_tail[3],
                         r_tail[4], r_tail[5], r_tail[6], r_tail[7]},
        trailing_error: r_error
    };

    // Group index never passes the done value
    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group <= GroupCount)
        else $error("group index out of range");

    // Digit count stays below the group's limit
    a_digits_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_group < GroupCount) |-> (r_digits < w_limit))
        else $error("digit count reached group limit without closing");

    // Between groups nothing is counted
    a_idle_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> (r_digits == 4'd0))
        else $error("digits counted while skipping");

    // Trailing error only once all groups are done
    a_error_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |-> (r_group == GroupCount))
        else $error("trailing error before last group");

    // End character returns the parser to its reset state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_end) |=> (r_group == 4'd0 && !r_error && r_first == 32'd0))
        else $error("state not cleared after end of string");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the GUID hex text parser: directed and random character streams checked per GUID.
`timescale 1ns / 100ps
module tb;
    import ghtp_pkg::*;

    logic clk;
    logic rst_n;

    ghtp_char_if   char_ch ();
    ghtp_result_if guid_ch ();

    guid_hex_text_parser dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_char   (char_ch),
        .o_result (guid_ch)
    );

    // Percent of cycles the sender idles and the receiver stalls
    int idle_pct  = 25;
    int stall_pct = 88;

    int mismatch_count = 0;
    int chars_sent     = 0;
    int guids_sent     = 0;

    // Parser model state
    logic [3:0] grp_idx;
    logic [3:0] digit_cnt;
    logic       in_group;
    t_result    guid_acc;
    t_result    pending_guids[$];

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Nibble of a hex character; bit 4 set when the character is not hex
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void clear_parser();
        grp_idx   = '0;
        digit_cnt = '0;
        in_group  = 1'b0;
        guid_acc  = '0;
    endfunction

    function automatic void close_group();
        grp_idx   = grp_idx + 4'd1;
        digit_cnt = '0;
        in_group  = 1'b0;
    endfunction

    // Advance the model by one accepted character; a zero byte queues the parsed GUID
    function automatic void parse_char(input logic [7:0] c);
        logic [4:0] nib;
        logic [3:0] lim;
        int         base;
        nib = nibble_of(c);
        if (c == EndChar) begin
            pending_guids.push_back(guid_acc);
            clear_parser();
        end else if (grp_idx >= GroupCount) begin
            if (!nib[4]) guid_acc.trailing_error = 1'b1;
        end else if (nib[4]) begin
            if (in_group) close_group();
        end else begin
            in_group = 1'b1;
            case (grp_idx)
                4'd0: begin
                    guid_acc.part_one = {guid_acc.part_one[27:0], nib[3:0]};
                    lim = FirstLimit;
                end
                4'd1: begin
                    guid_acc.part_two = {guid_acc.part_two[11:0], nib[3:0]};
                    lim = MidLimit;
                end
                4'd2: begin
                    guid_acc.part_three = {guid_acc.part_three[11:0], nib[3:0]};
                    lim = MidLimit;
                end
                default: begin
                    // first tail byte sits in the top bits
                    base = (7 - (int'(grp_idx) - int'(TailFirstGroup))) * 8;
                    guid_acc.tail_bytes[base +: 8] = {guid_acc.tail_bytes[base +: 4], nib[3:0]};
                    lim = TailLimit;
                end
            endcase
            digit_cnt = digit_cnt + 4'd1;
            if (digit_cnt >= lim) close_group();
        end
    endfunction

    task automatic note_mismatch(input string why, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %h %h %h %h %b, got %h %h %h %h %b", $realtime, why,
                     want.part_one, want.part_two, want.part_three, want.tail_bytes,
                     want.trailing_error, got.part_one, got.part_two, got.part_three,
                     got.tail_bytes, got.trailing_error);
    endtask

    // Result side: check each transaction, then pick the next ready level
    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && guid_ch.valid && guid_ch.ready) begin
            got.part_one       = guid_ch.part_one;
            got.part_two       = guid_ch.part_two;
            got.part_three     = guid_ch.part_three;
            got.tail_bytes     = guid_ch.tail_bytes;
            got.trailing_error = guid_ch.trailing_error;
            if (pending_guids.size() == 0) begin
                note_mismatch("unexpected GUID", '0, got);
            end else begin
                want = pending_guids.pop_front();
                if (got.part_one !== want.part_one || got.part_two !== want.part_two ||
                    got.part_three !== want.part_three ||
                    got.tail_bytes !== want.tail_bytes ||
                    got.trailing_error !== want.trailing_error)
                    note_mismatch("GUID mismatch", want, got);
            end
        end
        guid_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Send one character; returns once its transaction is done
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        do @(posedge clk); while (!char_ch.ready);
        parse_char(c);
        chars_sent++;
        if (c == EndChar) guids_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(15));
        if (v < 8'd10) return "0" + v;
        return ($urandom_range(1) ? "A" : "a") + v - 8'd10;
    endfunction

    // Any non-hex, non-zero character, high codes included
    function automatic logic [7:0] rand_separator();
        logic [7:0] c;
        logic [4:0] nib;
        case ($urandom_range(3))
            0: c = "-";
            1: c = 8'($urandom_range(128, 255));
            default: begin
                do begin
                    c   = 8'($urandom_range(1, 255));
                    nib = nibble_of(c);
                end while (!nib[4]);
            end
        endcase
        return c;
    endfunction

    // One random string: mostly well-formed GUIDs, some truncated, some plain noise
    task automatic send_random_guid();
        logic [7:0] txt[$];
        int         style;
        int         sep_mode;
        int         n;
        int         cut;
        logic       short_grp;
        style = $urandom_range(9);
        if (style < 8) begin
            sep_mode = $urandom_range(2);
            if ($urandom_range(1)) txt.push_back("{");
            for (int g = 0; g < 11; g++) begin
                n = (g == 0) ? 8 : (g < 3) ? 4 : 2;
                short_grp = ($urandom_range(9) == 0);
                if (short_grp) n = $urandom_range(1, n - 1 > 0 ? n - 1 : 1);
                for (int k = 0; k < n; k++) txt.push_back(rand_hex_char());
                // a short group needs a separator to end it
                if (short_grp || sep_mode == 2 && $urandom_range(1))
                    txt.push_back(rand_separator());
                else if (sep_mode == 0 && (g < 3 || g == 4))
                    txt.push_back("-");
            end
            case ($urandom_range(3))
                0: ;
                1: txt.push_back("}");
                2: begin
                    txt.push_back("}");
                    repeat ($urandom_range(1, 3)) txt.push_back(rand_separator());
                end
                default: begin
                    // text after the last group, hex digits included
                    repeat ($urandom_range(1, 4))
                        txt.push_back($urandom_range(1) ? rand_hex_char() : rand_separator());
                end
            endcase
            if (style == 7) begin
                cut = $urandom_range(txt.size());
                while (txt.size() > cut) void'(txt.pop_back());
            end
        end else begin
            repeat ($urandom_range(24))
                txt.push_back($urandom_range(1) ? rand_hex_char() : 8'($urandom_range(1, 255)));
        end
        txt.push_back(EndChar);
        foreach (txt[i]) send_char(txt[i]);
    endtask

    task automatic test_empty_text();
        send_char(EndChar);
    endtask

    // Short groups ended by non-hex and high codes, unreached groups zero
    task automatic test_short_text();
        send_string("fF");
        send_char(8'hFF);
        send_char("9");
        send_char(8'h80);
        send_char("a");
        send_char(8'h01);
        send_char(EndChar);
    endtask

    // Ninth digit starts the second group without a separator
    task automatic test_long_digit_run();
        send_string("FFFFFFFFF9");
        send_char(EndChar);
    endtask

    task automatic test_random_stream(input int send_idle, input int recv_stall,
                                      input int char_goal, input int guid_goal);
        int start_chars;
        int start_guids;
        idle_pct    = send_idle;
        stall_pct   = recv_stall;
        start_chars = chars_sent;
        start_guids = guids_sent;
        while (chars_sent - start_chars < char_goal || guids_sent - start_guids < guid_goal)
            send_random_guid();
    endtask

    initial begin
        rst_n             = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        guid_ch.ready     = 1'b0;
        clear_parser();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_text();
        test_short_text();
        test_long_digit_run();
        test_random_stream(25, 88, 260, 8);
        test_random_stream(88, 25, 260, 8);
        test_random_stream(0, 0, 260, 8);

        // drain outstanding GUIDs, then allow for the output latency
        char_ch.valid <= 1'b0;
        stall_pct = 0;
        while (pending_guids.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ghtp_pkg.sv
sv/ghtp_if.sv
sv/ghtp_hex_decode.sv
sv/ghtp_core.sv
sv/guid_hex_text_parser.sv
tb/sv/tb.sv
